FILE: hw/rtl/adbptd_pkg.sv
package adbptd_pkg;

    // Fixed field widths
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int ELAPSED_W    = 16;
    localparam int PAYLOAD_W    = 64;
    localparam int BYTE_TOTAL_W = 4;
    localparam int SYNC_TIME_W  = 16;

    // Defaults for the top-level parameters
    localparam int MAX_DATA_BYTES_DEF = 8;
    localparam int TIME_WIDTH_DEF     = 16;

    // Half-bit edges per byte (command or data)
    localparam int HALF_BITS = 16;

    // Command stop windows, both open intervals
    localparam int STOP_A_LO = 55;
    localparam int STOP_A_HI = 75;
    localparam int STOP_B_LO = 150;
    localparam int STOP_B_HI = 300;

    // Register reset values
    localparam logic [CFG_W-1:0] ATTN_MIN_RST     = 16'd750;
    localparam logic [CFG_W-1:0] ATTN_MAX_RST     = 16'd850;
    localparam logic [CFG_W-1:0] ONE_BIT_MAX_RST  = 16'd50;
    localparam logic [CFG_W-1:0] START_MIN_RST    = 16'd25;
    localparam logic [CFG_W-1:0] START_MAX_RST    = 16'd45;
    localparam logic [CFG_W-1:0] NO_DATA_TO_RST   = 16'd260;
    localparam logic [CFG_W-1:0] STOP_TO_RST      = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTN_MIN    = 3'd0,
        CFG_ATTN_MAX    = 3'd1,
        CFG_ONE_BIT_MAX = 3'd2,
        CFG_START_MIN   = 3'd3,
        CFG_START_MAX   = 3'd4,
        CFG_NO_DATA_TO  = 3'd5,
        CFG_STOP_TO     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_ATTN       = 3'd0,
        PH_SYNC       = 3'd1,
        PH_CMD        = 3'd2,
        PH_CMD_STOP   = 3'd3,
        PH_DATA_START = 3'd4,
        PH_START_BIT  = 3'd5,
        PH_DATA       = 3'd6,
        PH_MAYBE_STOP = 3'd7
    } t_phase;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_POLL = 1'b1
    } t_op;

    typedef struct packed {
        t_op                  operation;
        logic [ELAPSED_W-1:0] elapsed;
    } t_event;

    typedef struct packed {
        logic [1:0]              cmd_type;
        logic [3:0]              device_address;
        logic [1:0]              register_index;
        logic                    cmd_stop_seen;
        logic                    has_payload;
        logic                    start_bit_ok;
        logic [BYTE_TOTAL_W-1:0] byte_total;
        logic [PAYLOAD_W-1:0]    payload;
        logic                    data_stop_seen;
        logic [SYNC_TIME_W-1:0]  sync_time;
        logic                    overflow;
    } t_result;

endpackage

FILE: hw/rtl/adbptd_in_reg.sv
module adbptd_in_reg
    import adbptd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_operation,
    input  logic [ELAPSED_W-1:0] i_elapsed,
    input  logic                 i_advance,
    output logic                 o_ready,
    output logic                 o_evt_valid,
    output t_event               o_evt
);

    logic   r_valid;
    t_event r_evt;

    // Take a new word when empty or when the held word moves on
    assign o_ready     = !r_valid || i_advance;
    assign o_evt_valid = r_valid;
    assign o_evt       = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the word payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_evt.operation <= t_op'(i_operation);
            r_evt.elapsed   <= i_elapsed;
        end
    end

endmodule

FILE: hw/rtl/adbptd_decoder.sv
module adbptd_decoder
    import adbptd_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
    parameter int TIME_WIDTH     = TIME_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_evt_valid,
    input  t_event               i_evt,
    input  logic                 i_out_free,
    output logic                 o_advance,
    output logic                 o_emit,
    output t_result              o_result
);

    localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
    localparam int CNT_W = $clog2(MAX_DATA_BYTES + 1);
    localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam int HB_W  = $clog2(HALF_BITS);
    localparam logic [CNT_W-1:0] BYTES_FULL = CNT_W'(MAX_DATA_BYTES);
    localparam logic [HB_W-1:0]  HB_LAST    = HB_W'(HALF_BITS - 1);

    // Configuration registers
    logic [CFG_W-1:0] r_attn_min, r_attn_max, r_one_bit_max;
    logic [CFG_W-1:0] r_start_min, r_start_max, r_no_data_to, r_stop_to;

    // Decoder state
    t_phase                r_phase, n_phase;
    logic [HB_W-1:0]       r_hb, n_hb;
    logic                  r_skip, n_skip;
    logic [7:0]            r_shift, n_shift;
    logic [7:0]            r_fields, n_fields;
    logic                  r_cmd_stop, n_cmd_stop;
    logic                  r_payload, n_payload;
    logic                  r_start_ok, n_start_ok;
    logic                  r_data_stop, n_data_stop;
    logic                  r_overflow, n_overflow;
    logic [CNT_W-1:0]      r_bytes, n_bytes;
    logic [7:0]            r_store [MAX_DATA_BYTES];
    logic [7:0]            n_store [MAX_DATA_BYTES];
    logic [TIME_WIDTH-1:0] r_sync, n_sync;

    // Decode helpers
    logic [TIME_WIDTH-1:0] t_w;
    logic [CMP_W-1:0]      t_c;
    logic [CMP_W-1:0]      sync_c;
    logic                  is_one, hb_even, hb_last, room;
    logic [7:0]            bit_mask;
    logic [IDX_W-1:0]      wr_idx, nxt_idx;
    logic [CNT_W-1:0]      nxt_bytes;
    logic                  attn_ok, stop_ok, start_ok;
    logic                  poll_nodata, poll_stop, emit_cond;
    logic [PAYLOAD_W-1:0]  pay;

    assign t_w = TIME_WIDTH'(i_evt.elapsed);
    assign t_c = CMP_W'(t_w);

    assign is_one    = t_c < CMP_W'(r_one_bit_max);
    assign hb_even   = !r_hb[0];
    assign hb_last   = (r_hb == HB_LAST);
    assign bit_mask  = 8'h80 >> r_hb[HB_W-1:1];
    assign room      = r_bytes < BYTES_FULL;
    assign wr_idx    = r_bytes[IDX_W-1:0];
    assign nxt_bytes = r_bytes + CNT_W'(1);
    assign nxt_idx   = nxt_bytes[IDX_W-1:0];

    assign attn_ok  = (t_c > CMP_W'(r_attn_min)) && (t_c < CMP_W'(r_attn_max));
    assign start_ok = (t_c > CMP_W'(r_start_min)) && (t_c < CMP_W'(r_start_max));
    assign stop_ok  = ((t_c > CMP_W'(STOP_A_LO)) && (t_c < CMP_W'(STOP_A_HI))) ||
                      ((t_c > CMP_W'(STOP_B_LO)) && (t_c < CMP_W'(STOP_B_HI)));

    // Polls that close a packet
    assign poll_nodata = (i_evt.operation == OP_POLL) && (r_phase == PH_DATA_START) &&
                         (t_c > CMP_W'(r_no_data_to));
    assign poll_stop   = (i_evt.operation == OP_POLL) && (r_phase == PH_MAYBE_STOP) &&
                         (t_c > CMP_W'(r_stop_to));
    assign emit_cond   = poll_nodata || poll_stop;

    // Stall only a closing poll while the result register is full
    assign o_advance = i_evt_valid && (!emit_cond || i_out_free);
    assign o_emit    = i_evt_valid && emit_cond && i_out_free;

    // Gather stored bytes; bytes past the count read as zero
    always_comb begin
        pay = '0;
        for (int b = 0; b < MAX_DATA_BYTES; b++) begin
            if (CNT_W'(b) < r_bytes) begin
                pay[8*b +: 8] = r_store[b];
            end
        end
    end

    assign sync_c = CMP_W'(r_sync);

    always_comb begin
        o_result.cmd_type       = r_fields[3:2];
        o_result.device_address = r_fields[7:4];
        o_result.register_index = r_fields[1:0];
        o_result.cmd_stop_seen  = r_cmd_stop;
        o_result.has_payload    = poll_nodata ? 1'b0 : r_payload;
        o_result.start_bit_ok   = r_start_ok;
        o_result.byte_total     = BYTE_TOTAL_W'(r_bytes);
        o_result.payload        = pay;
        o_result.data_stop_seen = poll_stop ? 1'b1 : r_data_stop;
        o_result.sync_time      = sync_c[SYNC_TIME_W-1:0];
        o_result.overflow       = r_overflow;
    end

    // Next state for one word
    always_comb begin
        n_phase     = r_phase;
        n_hb        = r_hb;
        n_skip      = r_skip;
        n_shift     = r_shift;
        n_fields    = r_fields;
        n_cmd_stop  = r_cmd_stop;
        n_payload   = r_payload;
        n_start_ok  = r_start_ok;
        n_data_stop = r_data_stop;
        n_overflow  = r_overflow;
        n_bytes     = r_bytes;
        n_sync      = r_sync;
        n_store     = r_store;

        if (o_advance) begin
            if (i_evt.operation == OP_POLL) begin
                if (poll_nodata) begin
                    n_payload = 1'b0;
                    n_phase   = PH_ATTN;
                end else if (poll_stop) begin
                    n_data_stop = 1'b1;
                    n_phase     = PH_ATTN;
                end
            end else begin
                case (r_phase)
                    PH_ATTN: begin
                        // Open a fresh packet
                        if (attn_ok) begin
                            n_cmd_stop  = 1'b0;
                            n_payload   = 1'b0;
                            n_start_ok  = 1'b0;
                            n_data_stop = 1'b0;
                            n_overflow  = 1'b0;
                            n_bytes     = '0;
                            n_sync      = '0;
                            n_fields    = '0;
                            n_phase     = PH_SYNC;
                        end
                    end
                    PH_SYNC: begin
                        n_sync  = t_w;
                        n_hb    = '0;
                        n_shift = '0;
                        n_phase = PH_CMD;
                    end
                    PH_CMD: begin
                        // Shift in command bits, MSB first, on even half-bits
                        if (hb_even && is_one) begin
                            n_shift = r_shift | bit_mask;
                        end
                        n_hb = r_hb + HB_W'(1);
                        if (hb_last) begin
                            n_fields = r_shift;
                            n_phase  = PH_CMD_STOP;
                        end
                    end
                    PH_CMD_STOP: begin
                        if (stop_ok) begin
                            n_cmd_stop = 1'b1;
                            n_phase    = PH_DATA_START;
                        end else begin
                            n_phase = PH_ATTN;
                        end
                    end
                    PH_DATA_START: begin
                        n_payload = 1'b1;
                        n_phase   = PH_START_BIT;
                    end
                    PH_START_BIT: begin
                        if (start_ok) begin
                            n_start_ok = 1'b1;
                        end
                        n_skip = 1'b1;
                        n_hb   = '0;
                        if (room) begin
                            n_store[wr_idx] = '0;
                        end
                        n_phase = PH_DATA;
                    end
                    PH_DATA, PH_MAYBE_STOP: begin
                        n_phase = PH_DATA;
                        if (r_skip) begin
                            // Drop the edge after the start bit
                            n_skip = 1'b0;
                            n_hb   = '0;
                        end else begin
                            if (hb_even) begin
                                if (is_one) begin
                                    if (room) begin
                                        n_store[wr_idx] = r_store[wr_idx] | bit_mask;
                                    end
                                end else if (r_hb == '0) begin
                                    // A zero leading bit may be the data stop
                                    n_phase = PH_MAYBE_STOP;
                                end
                            end
                            n_hb = r_hb + HB_W'(1);
                            if (hb_last) begin
                                if (room) begin
                                    n_bytes = nxt_bytes;
                                    if (nxt_bytes < BYTES_FULL) begin
                                        n_store[nxt_idx] = '0;
                                    end
                                end else begin
                                    n_overflow = 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_ATTN;
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ATTN;
            r_hb        <= '0;
            r_skip      <= 1'b0;
            r_cmd_stop  <= 1'b0;
            r_payload   <= 1'b0;
            r_start_ok  <= 1'b0;
            r_data_stop <= 1'b0;
            r_overflow  <= 1'b0;
            r_bytes     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_hb        <= n_hb;
            r_skip      <= n_skip;
            r_cmd_stop  <= n_cmd_stop;
            r_payload   <= n_payload;
            r_start_ok  <= n_start_ok;
            r_data_stop <= n_data_stop;
            r_overflow  <= n_overflow;
            r_bytes     <= n_bytes;
        end
    end

    // Packet payload registers
    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_fields <= n_fields;
        r_sync   <= n_sync;
        r_store  <= n_store;
    end

    // Configuration writes; an unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attn_min    <= ATTN_MIN_RST;
            r_attn_max    <= ATTN_MAX_RST;
            r_one_bit_max <= ONE_BIT_MAX_RST;
            r_start_min   <= START_MIN_RST;
            r_start_max   <= START_MAX_RST;
            r_no_data_to  <= NO_DATA_TO_RST;
            r_stop_to     <= STOP_TO_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ATTN_MIN:    r_attn_min    <= i_cfg_data;
                CFG_ATTN_MAX:    r_attn_max    <= i_cfg_data;
                CFG_ONE_BIT_MAX: r_one_bit_max <= i_cfg_data;
                CFG_START_MIN:   r_start_min   <= i_cfg_data;
                CFG_START_MAX:   r_start_max   <= i_cfg_data;
                CFG_NO_DATA_TO:  r_no_data_to  <= i_cfg_data;
                CFG_STOP_TO:     r_stop_to     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/adbptd_out_reg.sv
module adbptd_out_reg
    import adbptd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held word leaves this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: hw/rtl/adb_pulse_timing_decoder_top.sv
// Channel   Direction  Handshake                  Word
// -------   ---------  -------------------------  ------------------------------------
// input     in         i_in_valid / o_in_ready    i_operation, i_elapsed
// result    out        o_out_valid / i_out_ready  o_cmd_type ... o_overflow
// config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// One input word is taken per cycle while no closing poll stalls; a word is held in the
// input register and decoded into the result register, which is loaded with a packet
// when its closing poll is decoded. Only a closing poll can stall, and only while the
// result register still holds an untaken packet. Synchronous active-low reset clears
// phase, counters, flags and restores the register defaults; no clearing pass
// is needed.
module adb_pulse_timing_decoder_top
    import adbptd_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
    parameter int TIME_WIDTH     = TIME_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_operation,
    input  logic [ELAPSED_W-1:0]    i_elapsed,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_cmd_type,
    output logic [3:0]              o_device_address,
    output logic [1:0]              o_register_index,
    output logic                    o_cmd_stop_seen,
    output logic                    o_has_payload,
    output logic                    o_start_bit_ok,
    output logic [BYTE_TOTAL_W-1:0] o_byte_total,
    output logic [PAYLOAD_W-1:0]    o_payload,
    output logic                    o_data_stop_seen,
    output logic [SYNC_TIME_W-1:0]  o_sync_time,
    output logic                    o_overflow
);

    logic    evt_valid;
    t_event  evt;
    logic    advance;
    logic    emit;
    logic    out_free;
    t_result dec_result;
    t_result out_result;

    adbptd_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_operation (i_operation),
        .i_elapsed   (i_elapsed),
        .i_advance   (advance),
        .o_ready     (o_in_ready),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    adbptd_decoder #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES),
        .TIME_WIDTH     (TIME_WIDTH)
    ) u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_evt_valid (evt_valid),
        .i_evt       (evt),
        .i_out_free  (out_free),
        .o_advance   (advance),
        .o_emit      (emit),
        .o_result    (dec_result)
    );

    adbptd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (dec_result),
        .i_ready  (i_out_ready),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    // Break out the result word
    assign o_cmd_type       = out_result.cmd_type;
    assign o_device_address = out_result.device_address;
    assign o_register_index = out_result.register_index;
    assign o_cmd_stop_seen  = out_result.cmd_stop_seen;
    assign o_has_payload    = out_result.has_payload;
    assign o_start_bit_ok   = out_result.start_bit_ok;
    assign o_byte_total     = out_result.byte_total;
    assign o_payload        = out_result.payload;
    assign o_data_stop_seen = out_result.data_stop_seen;
    assign o_sync_time      = out_result.sync_time;
    assign o_overflow       = out_result.overflow;

endmodule
